@@ hdl/ustok_pkg.sv @@
// Shared types and codes for the single-use token slot table.
// No dependencies; used by the interfaces, the slot memory and the top level.
package ustok_pkg;

    localparam int unsigned TOKEN_W = 64;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TTL_W   = 20;
    localparam int unsigned MIN_W   = 16;
    localparam int unsigned CFG_W   = 20;
    localparam int unsigned CFG_IDX_W = 2;

    // Item actions
    localparam logic [1:0] ACT_CLAIM   = 2'd0;
    localparam logic [1:0] ACT_INSTALL = 2'd1;
    localparam logic [1:0] ACT_CONSUME = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_CLAIMED   = 3'd0;
    localparam logic [2:0] ST_DISABLED  = 3'd1;
    localparam logic [2:0] ST_RATE      = 3'd2;
    localparam logic [2:0] ST_INSTALLED = 3'd3;
    localparam logic [2:0] ST_HIT       = 3'd4;
    localparam logic [2:0] ST_MISS      = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT = 2'd2;

    localparam logic [TTL_W-1:0] TTL_RESET = 20'd30000;
    localparam logic [MIN_W-1:0] MIN_RESET = 16'd250;

    localparam logic [7:0] TOKEN_BYTES = 8'd16;

    // One slot as stored in memory
    typedef struct packed {
        logic [TOKEN_W-1:0] hi;
        logic [TOKEN_W-1:0] lo;
        logic [TIME_W-1:0]  expiry;
    } t_slot;

endpackage

@@ hdl/ustok_if.sv @@
// Request and response channels of the token slot table.
// Depends on ustok_pkg for field widths.
interface ustok_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       action;
    logic [ustok_pkg::TIME_W-1:0]     now_ms;
    logic [ustok_pkg::TOKEN_W-1:0]    token_hi;
    logic [ustok_pkg::TOKEN_W-1:0]    token_lo;
    logic [7:0]                       token_length;

    modport source (output valid, action, now_ms, token_hi, token_lo, token_length,
                    input ready);
    modport sink   (input valid, action, now_ms, token_hi, token_lo, token_length,
                    output ready);
endinterface

interface ustok_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [ustok_pkg::TIME_W-1:0] claim_count;
    logic [3:0]                   slot_index;

    modport source (output valid, status, claim_count, slot_index, input ready);
    modport sink   (input valid, status, claim_count, slot_index, output ready);
endinterface

@@ hdl/single_use_token_slot_table_top.sv @@
// Top level of the single-use token slot table: sequencer, slot scan, registers.
// Depends on ustok_pkg, ustok_if (channels) and ustok_mem (slot storage).
//
//  channel    dir  handshake          payload
//  i_req      in   valid/ready        action, now_ms, token_hi, token_lo, token_length
//  o_rsp      out  valid/ready        status, claim_count, slot_index
//  i_cfg_*    in   write enable only  i_cfg_idx, i_cfg_data
//
// A claim goes straight to the final step. Install, and consume when enabled with
// a 16-byte token, walk the slots through the one memory read port (address, then
// compare on the registered data); a hit ends the walk early. Other consumes miss.
// Synchronous active-low reset clears control, counters, spent and written bits;
// an unwritten slot reads as zero. A stalled response holds in the output
// register; the next item is still taken and waits at its final step.
module single_use_token_slot_table_top #(
    parameter int unsigned SLOT_COUNT = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ustok_req_if.sink                           i_req,
    ustok_rsp_if.source                         o_rsp,
    input  logic                                i_cfg_we,
    input  logic [ustok_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ustok_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                         r_state;
    logic [1:0]                         r_act;
    logic [ustok_pkg::TIME_W-1:0]       r_now;
    logic [ustok_pkg::TOKEN_W-1:0]      r_hi;
    logic [ustok_pkg::TOKEN_W-1:0]      r_lo;
    logic                               r_hit;
    logic [IW-1:0]                      r_idx;
    logic [IW-1:0]                      r_best;
    logic [ustok_pkg::TIME_W-1:0]       r_best_exp;
    logic                               r_best_spent;
    logic [SLOT_COUNT-1:0]              r_spent;
    logic [SLOT_COUNT-1:0]              r_written;
    logic [ustok_pkg::TIME_W-1:0]       r_last;
    logic [ustok_pkg::TIME_W-1:0]       r_cnt;
    logic                               r_enabled;
    logic [ustok_pkg::TTL_W-1:0]        r_ttl;
    logic [ustok_pkg::MIN_W-1:0]        r_min;

    logic                               r_out_valid;
    logic [2:0]                         r_out_status;
    logic [ustok_pkg::TIME_W-1:0]       r_out_count;
    logic [3:0]                         r_out_slot;

    logic                               req_go;
    logic                               fin_go;
    logic                               mem_we;
    ustok_pkg::t_slot                   mem_wdata;
    ustok_pkg::t_slot                   mem_rdata;
    ustok_pkg::t_slot                   cur;
    logic [ustok_pkg::TIME_W-1:0]       age;
    logic                               cur_expired;
    logic                               cur_match;
    logic                               cur_better;
    logic [ustok_pkg::TIME_W-1:0]       since_claim;
    logic                               rate_hit;
    logic [2:0]                         n_status;
    logic [ustok_pkg::TIME_W-1:0]       n_count;
    logic [3:0]                         n_slot;

    ustok_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_best),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_go      = i_req.valid && (r_state == S_IDLE);
    assign fin_go      = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    // A never-written slot reads as all zero
    assign cur         = r_written[r_idx] ? mem_rdata : '0;
    assign age         = r_now - cur.expiry;
    assign cur_expired = !age[ustok_pkg::TIME_W-1];
    assign cur_match   = (cur.hi == r_hi) && (cur.lo == r_lo);
    assign cur_better  = (r_idx == '0)
                      || (r_spent[r_idx] && !r_best_spent)
                      || ((r_spent[r_idx] == r_best_spent) && (cur.expiry < r_best_exp));

    assign since_claim = r_now - r_last;
    assign rate_hit    = (r_last != '0) && (since_claim < {16'd0, r_min});

    assign mem_we           = fin_go && (r_act == ustok_pkg::ACT_INSTALL);
    assign mem_wdata.hi     = r_hi;
    assign mem_wdata.lo     = r_lo;
    assign mem_wdata.expiry = r_now + {12'd0, r_ttl};

    always_comb begin
        n_status = ustok_pkg::ST_MISS;
        n_count  = '0;
        n_slot   = '0;
        unique case (r_act)
            ustok_pkg::ACT_CLAIM: begin
                if (!r_enabled) begin
                    n_status = ustok_pkg::ST_DISABLED;
                end else if (rate_hit) begin
                    n_status = ustok_pkg::ST_RATE;
                end else begin
                    n_status = ustok_pkg::ST_CLAIMED;
                    n_count  = r_cnt + 32'd1;
                end
            end
            ustok_pkg::ACT_INSTALL: begin
                n_status = ustok_pkg::ST_INSTALLED;
                n_slot   = 4'(r_best);
            end
            default: begin
                n_status = r_hit ? ustok_pkg::ST_HIT : ustok_pkg::ST_MISS;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
            r_ttl     <= ustok_pkg::TTL_RESET;
            r_min     <= ustok_pkg::MIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ustok_pkg::CFG_ENABLED: r_enabled <= i_cfg_data[0];
                ustok_pkg::CFG_TTL:     r_ttl     <= i_cfg_data[ustok_pkg::TTL_W-1:0];
                ustok_pkg::CFG_MIN_INT: r_min     <= i_cfg_data[ustok_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Item payload, held for the whole walk
    always_ff @(posedge i_clk) begin
        if (req_go) begin
            r_act <= i_req.action;
            r_now <= i_req.now_ms;
            r_hi  <= i_req.token_hi;
            r_lo  <= i_req.token_lo;
        end
    end

    // Sequencer and slot scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hit        <= 1'b0;
            r_idx        <= '0;
            r_best       <= '0;
            r_best_exp   <= '0;
            r_best_spent <= 1'b0;
            r_spent      <= '0;
            r_written    <= '0;
            r_last       <= '0;
            r_cnt        <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_hit  <= 1'b0;
                    r_idx  <= '0;
                    r_best <= '0;
                    if (req_go) begin
                        unique case (i_req.action)
                            ustok_pkg::ACT_CLAIM:   r_state <= S_FIN;
                            ustok_pkg::ACT_INSTALL: r_state <= S_RD;
                            ustok_pkg::ACT_CONSUME: begin
                                if (r_enabled && (i_req.token_length == ustok_pkg::TOKEN_BYTES))
                                begin
                                    r_state <= S_RD;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            default: r_state <= S_IDLE;  // drop the unused action
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (r_act == ustok_pkg::ACT_INSTALL) begin
                        if (cur_better) begin
                            r_best       <= r_idx;
                            r_best_exp   <= cur.expiry;
                            r_best_spent <= r_spent[r_idx];
                        end
                        r_state <= (r_idx == LAST_IDX) ? S_FIN : S_RD;
                        r_idx   <= r_idx + IW'(1);
                    end else if (!r_spent[r_idx] && !cur_expired && cur_match) begin
                        // stop on the first live matching slot
                        r_spent[r_idx] <= 1'b1;
                        r_hit          <= 1'b1;
                        r_state        <= S_FIN;
                    end else begin
                        if (!r_spent[r_idx] && cur_expired) begin
                            r_spent[r_idx] <= 1'b1;
                        end
                        r_state <= (r_idx == LAST_IDX) ? S_FIN : S_RD;
                        r_idx   <= r_idx + IW'(1);
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_state <= S_IDLE;
                        if (r_act == ustok_pkg::ACT_INSTALL) begin
                            r_spent[r_best]   <= 1'b0;
                            r_written[r_best] <= 1'b1;
                        end
                        if ((r_act == ustok_pkg::ACT_CLAIM) && (n_status == ustok_pkg::ST_CLAIMED))
                        begin
                            r_last <= r_now;
                            r_cnt  <= n_count;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_status <= n_status;
            r_out_count  <= n_count;
            r_out_slot   <= n_slot;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.claim_count = r_out_count;
    assign o_rsp.slot_index  = r_out_slot;

    // An installed slot is live right after the write
    a_install_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && (r_act == ustok_pkg::ACT_INSTALL))
        |=> (!r_spent[$past(r_best)] && r_written[$past(r_best)]))
        else $error("installed slot not live");

    // A granted claim advances the counter by exactly one
    a_claim_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && (r_act == ustok_pkg::ACT_CLAIM) && (n_status == ustok_pkg::ST_CLAIMED))
        |=> (r_cnt == $past(r_cnt) + 32'd1) && (r_out_count == r_cnt))
        else $error("claim counter mismatch");

    // A hit always leaves a spent slot behind
    a_hit_spends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && (r_act == ustok_pkg::ACT_CONSUME) && r_hit)
        |=> ($countones(r_spent) != 0) && (r_out_status == ustok_pkg::ST_HIT))
        else $error("consume hit without spent slot");

    // The scan only runs for install and consume items
    a_scan_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_EV))
        |-> ((r_act == ustok_pkg::ACT_INSTALL) || (r_act == ustok_pkg::ACT_CONSUME)))
        else $error("slot scan for a claim");

endmodule

@@ hdl/ustok_mem.sv @@
// Slot memory: token halves and expiry, one write and one registered read port.
// Depends on ustok_pkg for the slot type.
module ustok_mem #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned AW    = 2
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  ustok_pkg::t_slot i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output ustok_pkg::t_slot o_rdata
);

    ustok_pkg::t_slot r_mem [DEPTH];
    ustok_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
